// ===== hw/rtl/baro_sensor_compensation_assert.svh =====
// ----------------------------------------------------------------------------
// Barometer compensation assertion macros
// Shared concurrent assertion forms for the compensation block.
// ----------------------------------------------------------------------------
`ifndef BARO_SENSOR_COMPENSATION_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BSC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("barometer compensation: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BSC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("barometer compensation: next-cycle check failed");

`endif

// ===== hw/rtl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation package
// Shared types, constants and fixed-point helpers.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int unsigned RawWidth    = 24;
   localparam int unsigned CentiWidth  = 16;
   localparam int unsigned PressWidth  = 18;
   localparam int unsigned TempRegW    = 40;
   localparam int unsigned PressRegW   = 64;
   localparam int unsigned CsrIdxW     = 2;
   localparam int unsigned ReqDataW    = 48;
   localparam int unsigned RspDataW    = 40;
   localparam int unsigned TempStages  = 5;
   localparam int unsigned PressStages = 7;
   localparam int unsigned Latency     = TempStages + PressStages;

   localparam logic [CsrIdxW-1:0] CSR_CALIB_TEMP    = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_CALIB_PRESS_A = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_CALIB_PRESS_B = 2'd2;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [7:0]  t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [7:0]  p3;
      logic [7:0]  p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [7:0]  p7;
      logic [7:0]  p8;
      logic [15:0] p9;
      logic [7:0]  p10;
      logic [7:0]  p11;
   } calib_type;

   function automatic calib_type unpack_calib(input logic [TempRegW-1:0] ct,
                                              input logic [PressRegW-1:0] pa,
                                              input logic [PressRegW-1:0] pb);
      calib_type c;
      c.t1  = ct[15:0];
      c.t2  = ct[31:16];
      c.t3  = ct[39:32];
      c.p1  = pa[15:0];
      c.p2  = pa[31:16];
      c.p3  = pa[39:32];
      c.p4  = pa[47:40];
      c.p5  = pa[63:48];
      c.p6  = pb[15:0];
      c.p7  = pb[23:16];
      c.p8  = pb[31:24];
      c.p9  = pb[47:32];
      c.p10 = pb[55:48];
      c.p11 = pb[63:56];
      return c;
   endfunction

   // Signed division by 2^k that truncates toward zero.
   function automatic logic signed [63:0] shr_tz(input logic signed [63:0] x,
                                                 input int unsigned k);
      logic signed [63:0] bias;
      bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
      return (x + bias) >>> k;
   endfunction

endpackage

// ===== hw/rtl/bsc_temp.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation temperature stages
// Five register stages from raw count to linear temperature and centi-degrees.
// ----------------------------------------------------------------------------
module bsc_temp (
   input  logic                              clock,
   input  logic                              adv,
   input  bsc_pkg::calib_type                cal,
   input  logic [bsc_pkg::RawWidth-1:0]      raw_t,
   input  logic [bsc_pkg::RawWidth-1:0]      raw_p,
   output logic signed [23:0]                tsat,
   output logic signed [bsc_pkg::CentiWidth-1:0] centi,
   output logic [bsc_pkg::RawWidth-1:0]      p_out
);
   import bsc_pkg::*;

   logic signed [24:0] d_ff;
   logic signed [41:0] a_ff;
   logic signed [49:0] dd_ff;
   logic signed [59:0] tsum_ff;
   logic signed [27:0] tlin_ff;
   logic signed [23:0] tsat_ff;
   logic signed [CentiWidth-1:0] centi_ff;
   logic [RawWidth-1:0] p_ff [TempStages];

   logic signed [63:0] d_in, a_in, dd_in, tsum_in, tlin_in, cm_in, cq_in;
   logic signed [CentiWidth-1:0] centi_in;
   logic signed [23:0] tsat_in;

   always_comb begin
      d_in    = $signed({40'd0, raw_t}) - $signed({40'd0, cal.t1, 8'd0});
      a_in    = $signed({1'b0, cal.t2}) * d_ff;
      dd_in   = d_ff * d_ff;
      tsum_in = (64'(a_ff) <<< 18) + 64'(dd_ff) * 64'($signed(cal.t3));
      tlin_in = shr_tz(64'(tsum_ff), 32);
      cm_in   = 64'(tlin_ff) * 64'sd25;
      cq_in   = shr_tz(cm_in, 14);
      if (cq_in > 64'sd32767) begin
         centi_in = 16'sh7FFF;
      end else if (cq_in < -64'sd32768) begin
         centi_in = 16'sh8000;
      end else begin
         centi_in = cq_in[15:0];
      end
      if (tlin_ff > 28'sd8388607) begin
         tsat_in = 24'sh7FFFFF;
      end else if (tlin_ff < -28'sd8388608) begin
         tsat_in = 24'sh800000;
      end else begin
         tsat_in = tlin_ff[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff     <= d_in[24:0];
         a_ff     <= a_in[41:0];
         dd_ff    <= dd_in[49:0];
         tsum_ff  <= tsum_in[59:0];
         tlin_ff  <= tlin_in[27:0];
         tsat_ff  <= tsat_in;
         centi_ff <= centi_in;
         p_ff[0]  <= raw_p;
         for (int i = 1; i < TempStages; i++) begin
            p_ff[i] <= p_ff[i-1];
         end
      end
   end

   assign tsat  = tsat_ff;
   assign centi = centi_ff;
   assign p_out = p_ff[TempStages-1];

endmodule

// ===== hw/rtl/bsc_press.sv =====
// ----------------------------------------------------------------------------
// Barometer compensation pressure stages
// Seven register stages evaluating the pressure polynomial with saturation.
// ----------------------------------------------------------------------------
module bsc_press (
   input  logic                                   clock,
   input  logic                                   adv,
   input  bsc_pkg::calib_type                     cal,
   input  logic signed [23:0]                     tsat,
   input  logic signed [bsc_pkg::CentiWidth-1:0]  centi_i,
   input  logic [bsc_pkg::RawWidth-1:0]           raw_p,
   output logic signed [bsc_pkg::CentiWidth-1:0]  centi_o,
   output logic [bsc_pkg::PressWidth-1:0]         pa_o
);
   import bsc_pkg::*;

   // Carry lines for the pressure count and the finished temperature.
   logic signed [24:0] p_ff [PressStages];
   logic signed [CentiWidth-1:0] c_ff [PressStages];

   // Stage 6
   logic signed [47:0] t2_ff;
   logic signed [23:0] tt_ff;
   logic signed [40:0] p6t_ff;
   logic signed [41:0] p2t_ff;
   logic signed [31:0] p10t_ff;
   logic signed [48:0] pp_ff;
   // Stage 7
   logic signed [55:0] t3_ff, p7t2_ff, p3t2_ff;
   logic signed [33:0] cc_ff;
   logic signed [56:0] p11pp_ff;
   logic signed [40:0] p6t7_ff;
   logic signed [41:0] p2t7_ff;
   // Stage 8
   logic signed [63:0] p8t3_ff, p4t3_ff;
   logic signed [58:0] cp_ff;
   logic signed [39:0] q11_ff;
   logic signed [51:0] offa_ff;
   logic signed [37:0] sensa_ff;
   // Stage 9
   logic signed [51:0] off9_ff;
   logic signed [37:0] sens_ff;
   logic signed [41:0] cpd_ff;
   logic signed [63:0] cubem_ff;
   // Stage 10
   logic signed [62:0] sp_ff;
   logic signed [63:0] quadm_ff;
   logic signed [45:0] cube_ff;
   logic signed [51:0] off10_ff;
   // Stage 11 and output
   logic signed [63:0] total_ff;
   logic [PressWidth-1:0] pa_ff;

   logic signed [24:0] ps_in;
   logic signed [63:0] t2_in, p6t_in, p2t_in, p10t_in, pp_in;
   logic signed [63:0] t3_in, p7t2_in, p3t2_in, cc_in, p11pp_in;
   logic signed [63:0] p8t3_in, p4t3_in, cp_in, q11_in, offa_in, sensa_in;
   logic signed [63:0] off9_in, sens_in, cpd_in, cubem_in;
   logic signed [63:0] sp_in, quadm_in, cube_in, total_in, rnd_in;
   logic [PressWidth-1:0] pa_in;

   always_comb begin
      ps_in    = $signed({1'b0, raw_p});
      t2_in    = 64'(tsat) * 64'(tsat);
      p6t_in   = 64'($signed({1'b0, cal.p6})) * 64'(tsat);
      p2t_in   = (64'($signed(cal.p2)) - 64'sd16384) * 64'(tsat);
      p10t_in  = 64'($signed(cal.p10)) * 64'(tsat);
      pp_in    = 64'(ps_in) * 64'(ps_in);

      t3_in    = (64'(t2_ff) >>> 16) * 64'(tt_ff);
      p7t2_in  = 64'($signed(cal.p7)) * 64'(t2_ff);
      p3t2_in  = 64'($signed(cal.p3)) * 64'(t2_ff);
      cc_in    = (64'($signed(cal.p9)) <<< 16) + 64'(p10t_ff);
      p11pp_in = 64'($signed(cal.p11)) * 64'(pp_ff);

      p8t3_in  = 64'($signed(cal.p8)) * 64'(t3_ff);
      p4t3_in  = 64'($signed(cal.p4)) * 64'(t3_ff);
      cp_in    = 64'(cc_ff) * 64'(p_ff[1]);
      q11_in   = shr_tz(64'(p11pp_ff), 17);
      offa_in  = (64'($signed({1'b0, cal.p5})) <<< 33) + (64'(p6t7_ff) <<< 8)
               + shr_tz(64'(p7t2_ff), 10);
      sensa_in = ((64'($signed(cal.p1)) - 64'sd16384) <<< 20)
               + shr_tz(64'(p2t7_ff), 5) + shr_tz(64'(p3t2_ff), 24);

      off9_in  = 64'(offa_ff) + shr_tz(p8t3_ff, 17);
      sens_in  = 64'(sensa_ff) + shr_tz(p4t3_ff, 29);
      cpd_in   = shr_tz(64'(cp_ff), 17);
      cubem_in = 64'(q11_ff) * 64'(p_ff[2]);

      sp_in    = 64'(sens_ff) * 64'(p_ff[3]);
      quadm_in = 64'(cpd_ff) * 64'(p_ff[3]);
      cube_in  = shr_tz(cubem_ff, 18);

      total_in = 64'(off10_ff) + shr_tz(64'(sp_ff), 10) + shr_tz(quadm_ff, 17)
               + 64'(cube_ff);

      // Round half up to whole pascal, clamp to the field range.
      rnd_in = (total_ff + 64'sd536870912) >>> 30;
      if (total_ff <= 64'sd0) begin
         pa_in = '0;
      end else if (rnd_in > 64'sd262143) begin
         pa_in = '1;
      end else begin
         pa_in = rnd_in[PressWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t2_ff    <= t2_in[47:0];
         tt_ff    <= tsat;
         p6t_ff   <= p6t_in[40:0];
         p2t_ff   <= p2t_in[41:0];
         p10t_ff  <= p10t_in[31:0];
         pp_ff    <= pp_in[48:0];

         t3_ff    <= t3_in[55:0];
         p7t2_ff  <= p7t2_in[55:0];
         p3t2_ff  <= p3t2_in[55:0];
         cc_ff    <= cc_in[33:0];
         p11pp_ff <= p11pp_in[56:0];
         p6t7_ff  <= p6t_ff;
         p2t7_ff  <= p2t_ff;

         p8t3_ff  <= p8t3_in;
         p4t3_ff  <= p4t3_in;
         cp_ff    <= cp_in[58:0];
         q11_ff   <= q11_in[39:0];
         offa_ff  <= offa_in[51:0];
         sensa_ff <= sensa_in[37:0];

         off9_ff  <= off9_in[51:0];
         sens_ff  <= sens_in[37:0];
         cpd_ff   <= cpd_in[41:0];
         cubem_ff <= cubem_in;

         sp_ff    <= sp_in[62:0];
         quadm_ff <= quadm_in;
         cube_ff  <= cube_in[45:0];
         off10_ff <= off9_ff;

         total_ff <= total_in;
         pa_ff    <= pa_in;

         p_ff[0] <= ps_in;
         c_ff[0] <= centi_i;
         for (int i = 1; i < PressStages; i++) begin
            p_ff[i] <= p_ff[i-1];
            c_ff[i] <= c_ff[i-1];
         end
      end
   end

   assign centi_o = c_ff[PressStages-1];
   assign pa_o    = pa_ff;

endmodule

// ===== hw/rtl/baro_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// Barometer sensor compensation
// Pipelined polynomial compensation of raw temperature and pressure counts.
// ----------------------------------------------------------------------------
// Each request beat carries one raw temperature and one raw pressure count and
// produces exactly one response beat holding the temperature in hundredths of
// a degree Celsius and the pressure in pascal, both saturated. The block takes
// a new beat on every clock cycle unless a result waits at the output. The
// pipeline is twelve register stages deep, five for the temperature and seven
// for the pressure polynomial, whose chain of dependent multiplies sets that
// depth. A result is offered when its beat leaves the last pressure stage.
// When a result waits at the output the whole pipeline holds and req_tready
// drops until it is taken. Calibration words are written through the csr
// port; the user must write them only while no beats are in flight, which
// the block itself does not enforce.
module baro_sensor_compensation (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: raw_temperature [23:0], raw_pressure [47:24]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [bsc_pkg::ReqDataW-1:0]         req_tdata,
   // rsp_tdata: temperature_centi [15:0], pressure_pa [33:16], zero [39:34]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bsc_pkg::RspDataW-1:0]         rsp_tdata,
   input  logic                                 csr_we,
   input  logic [bsc_pkg::CsrIdxW-1:0]          csr_index,
   input  logic [bsc_pkg::PressRegW-1:0]        csr_wdata
);
   import bsc_pkg::*;

`include "baro_sensor_compensation_assert.svh"

   logic [TempRegW-1:0]  calib_temp_ff;
   logic [PressRegW-1:0] calib_press_a_ff;
   logic [PressRegW-1:0] calib_press_b_ff;
   logic [Latency-1:0]   vld_ff;

   calib_type cal;
   logic      adv;
   logic signed [23:0] tsat;
   logic signed [CentiWidth-1:0] centi_mid, centi_out;
   logic [RawWidth-1:0]  p_mid;
   logic [PressWidth-1:0] pa_out;

   // Calibration registers; writes to the unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         calib_temp_ff    <= '0;
         calib_press_a_ff <= '0;
         calib_press_b_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CALIB_TEMP:    calib_temp_ff    <= csr_wdata[TempRegW-1:0];
            CSR_CALIB_PRESS_A: calib_press_a_ff <= csr_wdata;
            CSR_CALIB_PRESS_B: calib_press_b_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cal = unpack_calib(calib_temp_ff, calib_press_a_ff, calib_press_b_ff);

   // The pipeline moves whenever the output register is empty or being read.
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[Latency-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Latency-2:0], req_tvalid};
      end
   end

   bsc_temp u_temp (
      .clock (clock),
      .adv   (adv),
      .cal   (cal),
      .raw_t (req_tdata[RawWidth-1:0]),
      .raw_p (req_tdata[2*RawWidth-1:RawWidth]),
      .tsat  (tsat),
      .centi (centi_mid),
      .p_out (p_mid)
   );

   bsc_press u_press (
      .clock   (clock),
      .adv     (adv),
      .cal     (cal),
      .tsat    (tsat),
      .centi_i (centi_mid),
      .raw_p   (p_mid),
      .centi_o (centi_out),
      .pa_o    (pa_out)
   );

   assign rsp_tdata = {{(RspDataW - PressWidth - CentiWidth){1'b0}}, pa_out, centi_out};

   // A waiting result must hold the pipeline closed to new beats.
   `BSC_ASSERT_IMP(a_stall_blocks_req, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   // A taken request beat occupies the first stage on the next cycle.
   `BSC_ASSERT_NXT(a_req_enters, clock, reset, req_tvalid && req_tready, vld_ff[0])
   // Output drains when the stage behind it is empty.
   `BSC_ASSERT_NXT(a_out_drains, clock, reset,
                   rsp_tvalid && rsp_tready && !vld_ff[Latency-2], !rsp_tvalid)

endmodule
